// ----- rtl/core/ps2c_pkg.sv -----
// Shared constants and types for the scan polar-to-Cartesian converter.
// Used by every module in rtl/core; has no dependencies of its own.
package ps2c_pkg;

    // Default field widths (top-level parameter defaults)
    localparam int ANGLE_BITS_DEF = 16;
    localparam int RANGE_BITS_DEF = 18;

    // Beams at or past this index are dropped
    localparam int MAX_BEAMS = 4096;
    localparam int IDX_BITS  = 12;

    // Phase is a 32-bit turn: 2 quadrant bits over a Q30 fraction
    localparam int PHASE_BITS = 32;
    localparam int FRAC_BITS  = 30;
    localparam int MAG_BITS   = 31;
    localparam logic [MAG_BITS-1:0] Q30_ONE = 31'h4000_0000;

    // Odd Taylor terms of sin(pi/2*u), Q30, lowest order first
    localparam int HORNER_STEPS = 4;
    localparam logic [MAG_BITS-1:0] SIN_COEF [5] = '{
        31'd1686629713,
        31'd693598668,
        31'd85569306,
        31'd5026995,
        31'd172272
    };

    // Pipeline layout: angle stage, sine stages, scale stages
    localparam int SIN_STAGES   = HORNER_STEPS + 2;
    localparam int SCALE_STAGES = 2;
    localparam int NUM_STAGES   = 1 + SIN_STAGES + SCALE_STAGES;

    // APB register map (word index = paddr[3:2])
    localparam int ADDR_BITS = 4;
    typedef enum logic [1:0] {
        REG_RANGE_CAP   = 2'd0,
        REG_START_ANGLE = 2'd1,
        REG_ANGLE_STEP  = 2'd2
    } t_reg_idx;

    // Quadrant of the phase
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

endpackage

// ----- rtl/core/ps2c_angle.sv -----
// Entry stage: beam filter, beam angle multiply-add and phase split.
// Depends on ps2c_pkg.
module ps2c_angle #(
    parameter int ANGLE_BITS = ps2c_pkg::ANGLE_BITS_DEF,
    parameter int RANGE_BITS = ps2c_pkg::RANGE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [RANGE_BITS-1:0]             i_range_sample,
    input  logic                              i_range_finite,
    input  logic [ps2c_pkg::IDX_BITS-1:0]     i_beam_index,
    input  logic [RANGE_BITS-1:0]             i_range_cap,
    input  logic signed [ANGLE_BITS-1:0]      i_start_angle,
    input  logic [ANGLE_BITS-1:0]             i_angle_step,
    output logic                              o_keep,
    output logic [RANGE_BITS-1:0]             o_range,
    output logic [ps2c_pkg::IDX_BITS-1:0]     o_index,
    output ps2c_pkg::t_quad                   o_quad,
    output logic [ps2c_pkg::MAG_BITS-1:0]     o_u_sin,
    output logic [ps2c_pkg::MAG_BITS-1:0]     o_u_cos
);

    localparam int PROD_BITS = ANGLE_BITS + ps2c_pkg::IDX_BITS;

    logic [PROD_BITS-1:0]            w_step_prod;
    logic [ANGLE_BITS-1:0]           n_ang;
    logic [ANGLE_BITS-1:0]           r_ang;
    logic [ps2c_pkg::PHASE_BITS-1:0] w_phase;
    logic [ps2c_pkg::MAG_BITS-1:0]   w_frac;

    // Keep finite beams within range and inside the scan
    assign o_keep = i_range_finite && (i_range_sample <= i_range_cap) &&
                    (32'(i_beam_index) < 32'(ps2c_pkg::MAX_BEAMS));

    // Angle wraps modulo a full turn
    assign w_step_prod = PROD_BITS'(i_angle_step) * PROD_BITS'(i_beam_index);
    assign n_ang = ANGLE_BITS'($unsigned(i_start_angle) + w_step_prod[ANGLE_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang   <= n_ang;
            o_range <= i_range_sample;
            o_index <= i_beam_index;
        end
    end

    // Phase: quadrant in the top two bits, Q30 position below
    assign w_phase = ps2c_pkg::PHASE_BITS'(r_ang) << (ps2c_pkg::PHASE_BITS - ANGLE_BITS);
    assign o_quad  = ps2c_pkg::t_quad'(w_phase[ps2c_pkg::PHASE_BITS-1 -: 2]);
    assign w_frac  = {1'b0, w_phase[ps2c_pkg::FRAC_BITS-1:0]};
    assign o_u_sin = w_frac;
    assign o_u_cos = ps2c_pkg::Q30_ONE - w_frac;

endmodule

// ----- rtl/core/ps2c_qsin.sv -----
// Pipelined quarter-wave sine, Q30 in and out: square, four Horner steps,
// final multiply with clamp to one. Depends on ps2c_pkg.
module ps2c_qsin (
    input  logic                              i_clk,
    input  logic [ps2c_pkg::SIN_STAGES-1:0]   i_en,
    input  logic [ps2c_pkg::MAG_BITS-1:0]     i_u,
    output logic [ps2c_pkg::MAG_BITS-1:0]     o_mag
);

    localparam int MB = ps2c_pkg::MAG_BITS;
    localparam int NH = ps2c_pkg::HORNER_STEPS;
    localparam int FB = ps2c_pkg::FRAC_BITS;

    logic [MB-1:0]   r_u   [NH+1];
    logic [MB-1:0]   r_u2  [NH];
    logic [MB-1:0]   r_acc [NH];
    logic [2*MB-1:0] w_sq;
    logic [2*MB-1:0] w_fin;
    logic [MB:0]     w_fin_q;

    // Stage 0: register u and u^2 >> 30
    assign w_sq = (2*MB)'(i_u) * (2*MB)'(i_u);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_u[0]  <= i_u;
            r_u2[0] <= w_sq[FB+MB-1:FB];
        end
    end

    // Horner steps: acc = coef - (u2 * acc) >> 30
    for (genvar h = 0; h < NH; h++) begin : g_horner
        logic [MB-1:0]   w_acc_in;
        logic [2*MB-1:0] w_prod;

        if (h == 0) begin : g_first
            assign w_acc_in = ps2c_pkg::SIN_COEF[NH];
        end else begin : g_next
            assign w_acc_in = r_acc[h-1];
        end

        assign w_prod = (2*MB)'(r_u2[h]) * (2*MB)'(w_acc_in);

        always_ff @(posedge i_clk) begin
            if (i_en[h+1]) begin
                r_acc[h] <= ps2c_pkg::SIN_COEF[NH-1-h] - w_prod[FB+MB-1:FB];
                r_u[h+1] <= r_u[h];
            end
        end

        if (h + 1 < NH) begin : g_u2
            always_ff @(posedge i_clk) begin
                if (i_en[h+1]) begin
                    r_u2[h+1] <= r_u2[h];
                end
            end
        end
    end

    // Final stage: u * acc >> 30, clamped to one
    assign w_fin   = (2*MB)'(r_u[NH]) * (2*MB)'(r_acc[NH-1]);
    assign w_fin_q = w_fin[FB+MB:FB];

    always_ff @(posedge i_clk) begin
        if (i_en[NH+1]) begin
            o_mag <= (w_fin_q > (MB+1)'(ps2c_pkg::Q30_ONE)) ? ps2c_pkg::Q30_ONE
                                                             : w_fin_q[MB-1:0];
        end
    end

endmodule

// ----- rtl/core/ps2c_scale.sv -----
// Two-stage coordinate scale: range times magnitude with rounding, then sign.
// Depends on ps2c_pkg.
module ps2c_scale #(
    parameter int RANGE_BITS = ps2c_pkg::RANGE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic [ps2c_pkg::SCALE_STAGES-1:0]   i_en,
    input  logic [RANGE_BITS-1:0]               i_range,
    input  logic [ps2c_pkg::MAG_BITS-1:0]       i_mag,
    input  logic                                i_neg,
    output logic signed [RANGE_BITS:0]          o_coord
);

    localparam int PB = RANGE_BITS + ps2c_pkg::MAG_BITS;
    localparam int FB = ps2c_pkg::FRAC_BITS;

    logic [PB-1:0]         w_prod;
    logic [RANGE_BITS-1:0] r_val;
    logic                  r_neg;

    // Round half away from zero on the magnitude
    assign w_prod = PB'(i_range) * PB'(i_mag) + (PB'(1) << (FB - 1));

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_val <= w_prod[FB+RANGE_BITS-1:FB];
            r_neg <= i_neg;
        end
    end

    // Apply sign
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            o_coord <= r_neg ? -$signed({1'b0, r_val}) : $signed({1'b0, r_val});
        end
    end

endmodule

// ----- rtl/core/scan_polar_to_cartesian.sv -----
// Top level of the laser scan polar-to-Cartesian converter: APB registers,
// pipeline flow control and delay lines. Depends on ps2c_pkg, ps2c_angle,
// ps2c_qsin and ps2c_scale.
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+-------------------------------
//  beam    | in        | i_in_valid / o_in_ready       | range_sample, finite, index
//  point   | out       | o_out_valid / i_out_ready     | point_x, point_y, point_index
//  config  | in (APB)  | psel, penable, pwrite, pready | range cap, start_angle, step
//
// Nine register stages: angle, six quarter-sine stages (square, four Horner
// steps, final multiply), range scale and sign. One beam is taken per cycle
// while o_in_ready is high; dropped beams become bubbles. Each stage has its
// own valid bit and loads when it is empty or the next stage moves, so a
// stall at the output fills bubbles before it backs up to o_in_ready.
// Synchronous reset clears the valid bits and loads the register defaults.
module scan_polar_to_cartesian #(
    parameter int ANGLE_BITS = ps2c_pkg::ANGLE_BITS_DEF,
    parameter int RANGE_BITS = ps2c_pkg::RANGE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ps2c_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Beam input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [RANGE_BITS-1:0]             i_range_sample,
    input  logic                              i_range_finite,
    input  logic [ps2c_pkg::IDX_BITS-1:0]     i_beam_index,
    // Point output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [RANGE_BITS:0]        o_point_x,
    output logic signed [RANGE_BITS:0]        o_point_y,
    output logic [ps2c_pkg::IDX_BITS-1:0]     o_point_index
);

    localparam int NS = ps2c_pkg::NUM_STAGES;
    localparam int SS = ps2c_pkg::SIN_STAGES;
    localparam int CS = ps2c_pkg::SCALE_STAGES;
    localparam int IB = ps2c_pkg::IDX_BITS;
    localparam int MB = ps2c_pkg::MAG_BITS;

    // Configuration registers
    logic [RANGE_BITS-1:0]        r_range_cap;
    logic signed [ANGLE_BITS-1:0] r_start_angle;
    logic [ANGLE_BITS-1:0]        r_angle_step;
    ps2c_pkg::t_reg_idx           w_reg_idx;

    // Flow control
    logic [NS-1:0] r_vld;
    logic [NS:0]   w_rdy;

    // Datapath
    logic                  w_keep;
    logic [RANGE_BITS-1:0] w_range0;
    logic [IB-1:0]         w_index0;
    ps2c_pkg::t_quad       w_quad0;
    logic [MB-1:0]         w_u_sin;
    logic [MB-1:0]         w_u_cos;
    logic [MB-1:0]         w_mag_sin;
    logic [MB-1:0]         w_mag_cos;
    logic [RANGE_BITS-1:0] r_range_d [SS];
    ps2c_pkg::t_quad       r_quad_d  [SS];
    logic [IB-1:0]         r_index_d [NS-1];
    logic [MB-1:0]         w_mag_x;
    logic [MB-1:0]         w_mag_y;
    logic                  w_neg_x;
    logic                  w_neg_y;

    // APB register file
    assign pready    = 1'b1;
    assign w_reg_idx = ps2c_pkg::t_reg_idx'(paddr[ps2c_pkg::ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_cap   <= '1;
            r_start_angle <= '0;
            r_angle_step  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg_idx)
                ps2c_pkg::REG_RANGE_CAP:   r_range_cap   <= pwdata[RANGE_BITS-1:0];
                ps2c_pkg::REG_START_ANGLE: r_start_angle <= $signed(pwdata[ANGLE_BITS-1:0]);
                ps2c_pkg::REG_ANGLE_STEP:  r_angle_step  <= pwdata[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            ps2c_pkg::REG_RANGE_CAP:   prdata = 32'(r_range_cap);
            ps2c_pkg::REG_START_ANGLE: prdata = 32'($unsigned(r_start_angle));
            ps2c_pkg::REG_ANGLE_STEP:  prdata = 32'(r_angle_step);
            default:                   prdata = '0;
        endcase
    end

    // Stage ready chain: a stage loads when empty or when its successor moves
    always_comb begin
        w_rdy[NS] = i_out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[NS-1];

    // Valid bits; a dropped beam enters as a bubble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid && w_keep;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: filter and angle
    ps2c_angle #(
        .ANGLE_BITS (ANGLE_BITS),
        .RANGE_BITS (RANGE_BITS)
    ) u_angle (
        .i_clk          (i_clk),
        .i_en           (w_rdy[0]),
        .i_range_sample (i_range_sample),
        .i_range_finite (i_range_finite),
        .i_beam_index   (i_beam_index),
        .i_range_cap    (r_range_cap),
        .i_start_angle  (r_start_angle),
        .i_angle_step   (r_angle_step),
        .o_keep         (w_keep),
        .o_range        (w_range0),
        .o_index        (w_index0),
        .o_quad         (w_quad0),
        .o_u_sin        (w_u_sin),
        .o_u_cos        (w_u_cos)
    );

    // Stages 1..6: sine and cosine magnitudes
    ps2c_qsin u_qsin_sin (
        .i_clk (i_clk),
        .i_en  (w_rdy[SS:1]),
        .i_u   (w_u_sin),
        .o_mag (w_mag_sin)
    );

    ps2c_qsin u_qsin_cos (
        .i_clk (i_clk),
        .i_en  (w_rdy[SS:1]),
        .i_u   (w_u_cos),
        .o_mag (w_mag_cos)
    );

    // Range and quadrant ride alongside the sine pipeline
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_range_d[0] <= w_range0;
            r_quad_d[0]  <= w_quad0;
        end
        for (int k = 1; k < SS; k++) begin
            if (w_rdy[k+1]) begin
                r_range_d[k] <= r_range_d[k-1];
                r_quad_d[k]  <= r_quad_d[k-1];
            end
        end
    end

    // Index rides to the output
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_index_d[0] <= w_index0;
        end
        for (int k = 1; k < NS - 1; k++) begin
            if (w_rdy[k+1]) begin
                r_index_d[k] <= r_index_d[k-1];
            end
        end
    end

    assign o_point_index = r_index_d[NS-2];

    // Quadrant folding onto the first-quadrant magnitudes
    always_comb begin
        case (r_quad_d[SS-1])
            ps2c_pkg::QUAD_0: begin
                w_mag_x = w_mag_cos; w_neg_x = 1'b0;
                w_mag_y = w_mag_sin; w_neg_y = 1'b0;
            end
            ps2c_pkg::QUAD_1: begin
                w_mag_x = w_mag_sin; w_neg_x = 1'b1;
                w_mag_y = w_mag_cos; w_neg_y = 1'b0;
            end
            ps2c_pkg::QUAD_2: begin
                w_mag_x = w_mag_cos; w_neg_x = 1'b1;
                w_mag_y = w_mag_sin; w_neg_y = 1'b1;
            end
            default: begin
                w_mag_x = w_mag_sin; w_neg_x = 1'b0;
                w_mag_y = w_mag_cos; w_neg_y = 1'b1;
            end
        endcase
    end

    // Stages 7..8: scale and sign
    ps2c_scale #(
        .RANGE_BITS (RANGE_BITS)
    ) u_scale_x (
        .i_clk   (i_clk),
        .i_en    (w_rdy[SS+CS:SS+1]),
        .i_range (r_range_d[SS-1]),
        .i_mag   (w_mag_x),
        .i_neg   (w_neg_x),
        .o_coord (o_point_x)
    );

    ps2c_scale #(
        .RANGE_BITS (RANGE_BITS)
    ) u_scale_y (
        .i_clk   (i_clk),
        .i_en    (w_rdy[SS+CS:SS+1]),
        .i_range (r_range_d[SS-1]),
        .i_mag   (w_mag_y),
        .i_neg   (w_neg_y),
        .o_coord (o_point_y)
    );

endmodule
